/* rtl/mbe_pkg.sv */
package mbe_pkg;

  // Q4.28 limits and the escape threshold of 4.0
  localparam logic signed [31:0] QMax  = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin  = 32'sh8000_0000;
  localparam logic signed [31:0] FourQ = 32'sh4000_0000;

  localparam int unsigned FracBits = 28;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned IterW    = 16;
  localparam int unsigned CountW   = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgIterMax = 3'd0,
    CfgXMin    = 3'd1,
    CfgYMin    = 3'd2,
    CfgXStep   = 3'd3,
    CfgYStep   = 3'd4
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StCoord,
    StMul,
    StEval,
    StDone
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic coord;
    logic mul;
    logic eval;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic iter_zero;
    logic escape;
    logic last_iter;
  } status_t;

  // Saturate a wide signed value to Q4.28
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(QMax)) begin
      r = QMax;
    end else if (v < 64'(QMin)) begin
      r = QMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/mbe_ctrl.sv */
module mbe_ctrl import mbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCoord;
        end
      end
      StCoord: begin
        cmd_o.coord = 1'b1;
        state_d     = status_i.iter_zero ? StDone : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StEval;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = (status_i.escape || status_i.last_iter) ? StDone : StMul;
      end
      StDone: begin
        // Hand the count over once the output register is free or draining.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/mbe_dp.sv */
module mbe_dp import mbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [IdxW-1:0]     row_i,
  input  logic [IdxW-1:0]     column_i,
  output logic [CountW-1:0]   escape_count_o,
  input  cmd_t                cmd_i,
  output status_t             status_o
);

  localparam int unsigned ProdW = 31 + IdxW;

  logic [IterW-1:0]   iter_max_q;
  logic signed [31:0] x_min_q, y_min_q;
  logic [30:0]        x_step_q, y_step_q;

  logic [ProdW-1:0]   prod_x_q, prod_y_q;
  logic signed [31:0] cre_q, cim_q, re_q, im_q;
  logic signed [63:0] rr_p_q, ii_p_q, ri_p_q;
  logic [IterW-1:0]   n_q;
  logic [CountW-1:0]  res_q, count_q;

  logic signed [42:0] cx_sum, cy_sum;
  logic signed [31:0] rr, ii, ri2, mag, diff, re_n, im_n;
  logic signed [32:0] mag_w, diff_w, re_w, im_w;
  logic [CountW-1:0]  limit_cnt;
  logic               escape;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_max_q <= 16'd20;
      x_min_q    <= -32'sd536870912;
      y_min_q    <= -32'sd402653184;
      x_step_q   <= 31'd8053064;
      y_step_q   <= 31'd8053064;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIterMax: iter_max_q <= cfg_wdata_i[IterW-1:0];
        CfgXMin:    x_min_q    <= signed'(cfg_wdata_i);
        CfgYMin:    y_min_q    <= signed'(cfg_wdata_i);
        CfgXStep:   x_step_q   <= cfg_wdata_i[30:0];
        CfgYStep:   y_step_q   <= cfg_wdata_i[30:0];
        default:    ;
      endcase
    end
  end

  // Point coordinates: min plus the registered step product, saturated
  assign cx_sum = 43'(x_min_q) + 43'(signed'({1'b0, prod_x_q}));
  assign cy_sum = 43'(y_min_q) + 43'(signed'({1'b0, prod_y_q}));

  // Iteration step from the registered products
  assign rr     = sat_q(rr_p_q >>> FracBits);
  assign ii     = sat_q(ii_p_q >>> FracBits);
  assign ri2    = sat_q(ri_p_q >>> (FracBits - 1));
  assign mag_w  = 33'(rr) + 33'(ii);
  assign mag    = sat_q(64'(mag_w));
  assign escape = mag > FourQ;
  assign diff_w = 33'(rr) - 33'(ii);
  assign diff   = sat_q(64'(diff_w));
  assign re_w   = 33'(diff) + 33'(cre_q);
  assign re_n   = sat_q(64'(re_w));
  assign im_w   = 33'(ri2) + 33'(cim_q);
  assign im_n   = sat_q(64'(im_w));

  assign limit_cnt = {1'b0, iter_max_q} + 17'd1;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      prod_x_q <= ProdW'(x_step_q) * ProdW'(column_i);
      prod_y_q <= ProdW'(y_step_q) * ProdW'(row_i);
    end
    if (cmd_i.coord) begin
      cre_q <= sat_q(64'(cx_sum));
      cim_q <= sat_q(64'(cy_sum));
      re_q  <= '0;
      im_q  <= '0;
      n_q   <= '0;
      res_q <= limit_cnt;
    end
    if (cmd_i.mul) begin
      rr_p_q <= 64'(re_q) * 64'(re_q);
      ii_p_q <= 64'(im_q) * 64'(im_q);
      ri_p_q <= 64'(re_q) * 64'(im_q);
    end
    if (cmd_i.eval) begin
      re_q  <= re_n;
      im_q  <= im_n;
      n_q   <= n_q + 16'd1;
      res_q <= escape ? {1'b0, n_q} : limit_cnt;
    end
    if (cmd_i.out_load) begin
      count_q <= res_q;
    end
  end

  // Status towards the controller
  assign status_o.iter_zero = (iter_max_q == '0);
  assign status_o.escape    = escape;
  assign status_o.last_iter = (({1'b0, n_q} + 17'd1) == {1'b0, iter_max_q});

  assign escape_count_o = count_q;

endmodule

/* rtl/mandelbrot_escape_time_core.sv */
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    row_i[9:0], column_i[9:0]
// out      output     out_valid_o / out_ready_i  escape_count_o[16:0]
// cfg      input      cfg_we_i (no wait)         cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
// One pixel at a time: a pixel that runs k escape tests goes from one input beat
// to the next through the step products, the point coordinates, k escape tests
// (each the square products, then saturating update and test) and moving the
// count out. k is at most iter_max.
// Reset clears the controller and loads the default register values.
// A result waiting on out_ready_i stalls the next finished result, and only then input.
module mandelbrot_escape_time_core import mbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [IdxW-1:0]     row_i,
  input  logic [IdxW-1:0]     column_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CountW-1:0]   escape_count_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Fixed-point datapath and configuration registers
  mbe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .escape_count_o (escape_count_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule
